// ===== sv/gdd_pkg.sv =====
// Shared types, constants and calendar helpers for the date decrement core.
// No dependencies; imported by every module of the block.
`default_nettype none

package gdd_pkg;

  localparam int CNT_W   = 12;
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int CMD_W   = 3;
  localparam int FAC_W   = 10;
  localparam int MULT_W  = CNT_W + FAC_W;
  localparam int STEP_W  = 15;
  localparam int RES_W   = 9;
  localparam int YEAR_IO_W = 16;

  localparam logic [RES_W-1:0] CYCLE_YEARS = 9'd400;
  localparam logic [RES_W-1:0] RES_LAST    = 9'd399;

  typedef enum logic [CMD_W-1:0] {
    CMD_DAY        = 3'd0,
    CMD_WEEK       = 3'd1,
    CMD_MONTH      = 3'd2,
    CMD_YEAR       = 3'd3,
    CMD_DECADE     = 3'd4,
    CMD_CENTURY    = 3'd5,
    CMD_MILLENNIUM = 3'd6
  } cmd_e_t;

  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_DAY   = 2'd1,
    OP_MONTH = 2'd2,
    OP_YEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_RES  = 2'd1,
    F_PUSH = 2'd2,
    F_QUO  = 2'd3
  } fstate_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_RUN  = 2'd1,
    B_OUT  = 2'd2
  } bstate_t;

  typedef struct packed {
    op_t               kind;
    logic              bad;
    logic [MULT_W-1:0] mult;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [RES_W-1:0]  res;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [FAC_W-1:0] unit_factor(input logic [CMD_W-1:0] cmd);
    logic [FAC_W-1:0] f;
    case (cmd)
      CMD_WEEK:       f = 10'd7;
      CMD_DECADE:     f = 10'd10;
      CMD_CENTURY:    f = 10'd100;
      CMD_MILLENNIUM: f = 10'd1000;
      default:        f = 10'd1;
    endcase
    return f;
  endfunction

  // res is the year modulo 400; divisibility does not depend on sign
  function automatic logic is_leap(input logic [RES_W-1:0] res);
    logic cent;
    cent = (res == 9'd100) || (res == 9'd200) || (res == 9'd300);
    return (res[1:0] == 2'b00) && !cent;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    if (month == 4'd0 || month > 4'd12) begin
      d = '0;
    end else if (month == 4'd2) begin
      d = leap ? 5'd29 : 5'd28;
    end else begin
      d = MONTH_LEN[month - 4'd1];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gregorian_date_decrement_core.sv =====
// Top level of the Gregorian date decrement core: front end, job queue, back end.
// Depends on gdd_pkg, gdd_front, gdd_queue and gdd_back.
//
// Moves a date (day, month, signed year) back by a count of days, weeks, months,
// years, decades, centuries or millennia; invalid dates come back unchanged with
// the bad-input flag set. The front end takes no new item until the last has passed
// its year-modulo-400 reduction and its push, which waits while the queue is full.
// The back end takes one step per cycle on a day, week or month item and subtracts
// the year offset for the other units. A two-entry queue and an output register let
// the front end accept new items while the back end works or a result waits.
`default_nettype none

module gregorian_date_decrement_core import gdd_pkg::*; #(
  parameter int YEAR_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // command
  input  wire logic [39:0] in_tdata,   // step_count, day_in, month_in, year_in, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [0:0]       out_tuser,  // bad_input
  output logic [31:0]      out_tdata   // day_out, month_out, year_out, zero pad
);

  localparam int JOB_W = $bits(job_t) + YEAR_WIDTH;

  qstat_t                 qstat;
  logic                   push, pop;
  job_t                   f_job, b_job;
  logic [YEAR_WIDTH-1:0]  f_year, b_year;
  logic [JOB_W-1:0]       q_rd;
  logic [DAY_W-1:0]       out_day;
  logic [MON_W-1:0]       out_month;
  logic [YEAR_IO_W-1:0]   out_year;
  logic                   out_bad;

  gdd_front #(.YEAR_WIDTH(YEAR_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_count  (in_tdata[11:0]),
    .in_day    (in_tdata[16:12]),
    .in_month  (in_tdata[20:17]),
    .in_year   (in_tdata[36:21]),
    .qstat     (qstat),
    .push      (push),
    .job       (f_job),
    .job_year  (f_year)
  );

  gdd_queue #(.WIDTH(JOB_W)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data ({f_job, f_year}),
    .pop     (pop),
    .rd_data (q_rd),
    .qstat   (qstat)
  );

  assign b_job  = q_rd[JOB_W-1:YEAR_WIDTH];
  assign b_year = q_rd[YEAR_WIDTH-1:0];

  gdd_back #(.YEAR_WIDTH(YEAR_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .job        (b_job),
    .job_year   (b_year),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .out_bad    (out_bad)
  );

  assign out_tuser = out_bad;
  assign out_tdata = {7'd0, out_year, out_month, out_day};

endmodule

`default_nettype wire

// ===== sv/gdd_queue.sv =====
// Two-entry job queue between the classifying front end and the stepping back end.
// Uses gdd_pkg for the status struct.
`default_nettype none

module gdd_queue import gdd_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output qstat_t                qstat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && (cnt_r != 2'd0);
  assign rd_data = mem_r[rd_ptr_r];
  assign qstat   = '{full: (cnt_r == 2'd2), empty: (cnt_r == 2'd0)};

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== sv/gdd_front.sv =====
// Front end: accepts items, finds the year modulo 400 by reciprocal multiplication,
// checks the date and queues a classified job. Uses gdd_pkg.
`default_nettype none

module gdd_front import gdd_pkg::*; #(
  parameter int YEAR_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [CNT_W-1:0]      in_count,
  input  wire logic [DAY_W-1:0]      in_day,
  input  wire logic [MON_W-1:0]      in_month,
  input  wire logic [YEAR_IO_W-1:0]  in_year,
  input  qstat_t                     qstat,
  output logic                       push,
  output job_t                       job,
  output logic [YEAR_WIDTH-1:0]      job_year
);

  // floor(mag / 400) = (mag * RECIP) >> SHIFT, exact for any YEAR_WIDTH-bit magnitude
  localparam int SHIFT  = YEAR_WIDTH + RES_W;
  localparam int PROD_W = 2 * YEAR_WIDTH + 1;
  localparam int QUO_W  = PROD_W - SHIFT;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(CYCLE_YEARS) - 64'd1) / 64'(CYCLE_YEARS);
  localparam logic [YEAR_WIDTH:0] RECIP = RECIP_64[YEAR_WIDTH:0];

  fstate_t                fstate_r, fstate_nxt;
  logic [CMD_W-1:0]       cmd_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [DAY_W-1:0]       day_r;
  logic [MON_W-1:0]       month_r;
  logic [YEAR_WIDTH-1:0]  year_r, mag_r, year_w;
  logic                   neg_r;
  logic [QUO_W-1:0]       quo_r;
  logic [RES_W-1:0]       res_r, res_nxt;
  logic [MULT_W-1:0]      mult_r;
  logic                   accept;
  logic [PROD_W-1:0]      prod;
  logic [YEAR_WIDTH-1:0]  quo_x400, rem_w;
  logic [RES_W-1:0]       yres;
  logic                   leap, bad;

  assign year_w   = YEAR_WIDTH'(in_year);
  assign accept   = in_tvalid && in_tready;
  assign prod     = PROD_W'(mag_r) * PROD_W'(RECIP);
  assign quo_x400 = YEAR_WIDTH'(quo_r) * YEAR_WIDTH'(CYCLE_YEARS);
  assign rem_w    = mag_r - quo_x400;
  assign res_nxt  = rem_w[RES_W-1:0];

  always_comb begin
    yres = (neg_r && res_r != '0) ? CYCLE_YEARS - res_r : res_r;
    leap = is_leap(yres);
    bad  = (month_r == 4'd0) || (month_r > 4'd12) || (day_r == '0) ||
           (day_r > month_days(month_r, leap));
  end

  always_comb begin
    job.bad   = bad;
    job.mult  = mult_r;
    job.day   = day_r;
    job.month = month_r;
    job.res   = yres;
    if (bad || cnt_r == '0) begin
      job.kind = OP_PASS;
    end else begin
      case (cmd_r)
        CMD_DAY, CMD_WEEK:  job.kind = OP_DAY;
        CMD_MONTH:          job.kind = OP_MONTH;
        CMD_YEAR, CMD_DECADE, CMD_CENTURY, CMD_MILLENNIUM: job.kind = OP_YEAR;
        default:            job.kind = OP_PASS;
      endcase
    end
    job_year = year_r;
  end

  always_comb begin
    fstate_nxt = fstate_r;
    case (fstate_r)
      F_IDLE: if (in_tvalid) fstate_nxt = F_QUO;
      F_QUO:  fstate_nxt = F_RES;
      F_RES:  fstate_nxt = F_PUSH;
      F_PUSH: if (!qstat.full) fstate_nxt = F_IDLE;
      default: fstate_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    push      = 1'b0;
    case (fstate_r)
      F_IDLE:  in_tready = 1'b1;
      F_PUSH:  push = !qstat.full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
    end else begin
      fstate_r <= fstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      cnt_r   <= in_count;
      day_r   <= in_day;
      month_r <= in_month;
      year_r  <= year_w;
      neg_r   <= year_w[YEAR_WIDTH-1];
      mag_r   <= year_w[YEAR_WIDTH-1] ? (~year_w + 1'b1) : year_w;
      mult_r  <= MULT_W'(in_count) * MULT_W'(unit_factor(in_cmd));
    end else if (fstate_r == F_QUO) begin
      quo_r <= prod[PROD_W-1:SHIFT];
    end else if (fstate_r == F_RES) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gdd_back.sv =====
// Back end: steps a queued job one day or one month per cycle, or subtracts the
// year offset, and holds the result in an output register. Uses gdd_pkg.
`default_nettype none

module gdd_back import gdd_pkg::*; #(
  parameter int YEAR_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  qstat_t                     qstat,
  input  job_t                       job,
  input  wire logic [YEAR_WIDTH-1:0] job_year,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [DAY_W-1:0]           out_day,
  output logic [MON_W-1:0]           out_month,
  output logic [YEAR_IO_W-1:0]       out_year,
  output logic                       out_bad
);

  localparam logic [63:0] YEAR_MAX = (64'd1 << (YEAR_WIDTH - 1)) - 64'd1;
  localparam logic [RES_W-1:0] MAX_RES = RES_W'(YEAR_MAX % 64'd400);
  localparam int SUB_W = (YEAR_WIDTH > MULT_W) ? YEAR_WIDTH : MULT_W;

  bstate_t                bstate_r, bstate_nxt;
  op_t                    kind_r;
  logic                   bad_r;
  logic [STEP_W-1:0]      left_r;
  logic [MULT_W-1:0]      delta_r;
  logic [DAY_W-1:0]       day_r, day_nxt;
  logic [MON_W-1:0]       month_r, month_nxt;
  logic [YEAR_WIDTH-1:0]  year_r, year_nxt, year_dec;
  logic [RES_W-1:0]       res_r, res_nxt, res_dec;
  logic                   out_valid_r;
  logic                   load_out, running, run_done;
  logic [SUB_W-1:0]       diff;
  logic [MON_W-1:0]       prev_month;
  logic [DAY_W-1:0]       len;

  assign out_tvalid = out_valid_r;
  assign run_done = (kind_r == OP_YEAR) || (kind_r == OP_PASS) || (left_r == '0);
  assign year_dec = year_r - 1'b1;
  assign res_dec  = (year_r[YEAR_WIDTH-1] && year_r[YEAR_WIDTH-2:0] == '0) ? MAX_RES :
                    (res_r == '0) ? RES_LAST : res_r - 1'b1;
  assign diff = SUB_W'(year_r) - SUB_W'(delta_r);

  always_comb begin
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    res_nxt    = res_r;
    prev_month = month_r - 1'b1;
    len        = '0;
    case (kind_r)
      OP_DAY: begin
        if (day_r > 5'd1) begin
          day_nxt = day_r - 1'b1;
        end else if (month_r == 4'd1) begin
          month_nxt = 4'd12;
          day_nxt   = 5'd31;
          year_nxt  = year_dec;
          res_nxt   = res_dec;
        end else begin
          month_nxt = prev_month;
          day_nxt   = month_days(prev_month, is_leap(res_r));
        end
      end
      OP_MONTH: begin
        if (month_r == 4'd1) begin
          month_nxt = 4'd12;
          year_nxt  = year_dec;
          res_nxt   = res_dec;
        end else begin
          month_nxt = prev_month;
        end
        len = month_days(month_nxt, is_leap(res_nxt));
        if (day_r > len) day_nxt = len;
      end
      OP_YEAR: year_nxt = diff[YEAR_WIDTH-1:0];
      default: ;
    endcase
  end

  always_comb begin
    bstate_nxt = bstate_r;
    case (bstate_r)
      B_IDLE: if (!qstat.empty) bstate_nxt = B_RUN;
      B_RUN:  if (run_done) bstate_nxt = B_OUT;
      B_OUT:  if (!out_valid_r || out_tready) bstate_nxt = B_IDLE;
      default: bstate_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    running  = 1'b0;
    load_out = 1'b0;
    case (bstate_r)
      B_IDLE:  pop = !qstat.empty;
      B_RUN:   running = 1'b1;
      B_OUT:   load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= job.kind;
      bad_r   <= job.bad;
      left_r  <= job.mult[STEP_W-1:0];
      delta_r <= job.mult;
      day_r   <= job.day;
      month_r <= job.month;
      year_r  <= job_year;
      res_r   <= job.res;
    end else if (running && !run_done) begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      res_r   <= res_nxt;
      left_r  <= left_r - 1'b1;
    end else if (running && kind_r == OP_YEAR) begin
      year_r <= year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_day   <= day_r;
      out_month <= month_r;
      out_year  <= YEAR_IO_W'(year_r);
      out_bad   <= bad_r;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_date_decrement_core: directed and random date items.
// Depends on gdd_pkg and the core RTL; a scoreboard class predicts each result item.

module tb;
  import gdd_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        bad;
  } date_res_t;

  class date_scoreboard;
    date_res_t expected_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit leap(logic [15:0] y);
      int v;
      int a;
      v = int'($signed(y));
      a = (v < 0) ? -v : v;
      return ((a % 4 == 0) && (a % 100 != 0)) || (a % 400 == 0);
    endfunction

    function int days_of(logic [15:0] y, int m);
      int len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        4, 6, 9, 11:           len = 30;
        2:                     len = leap(y) ? 29 : 28;
        default:               len = 0;
      endcase
      return len;
    endfunction

    function void prev_day(inout int d, inout int m, inout logic [15:0] y);
      if (d > 1) begin
        d--;
      end else if (m == 1) begin
        m = 12;
        d = 31;
        y = y - 16'd1;
      end else begin
        m--;
        d = days_of(y, m);
      end
    endfunction

    function void prev_month(inout int d, inout int m, inout logic [15:0] y);
      int len;
      if (m == 1) begin
        m = 12;
        y = y - 16'd1;
      end else begin
        m--;
      end
      len = days_of(y, m);
      if (d > len) d = len;
    endfunction

    function void note_input(logic [2:0] cmd, logic [11:0] cnt, logic [4:0] d_in,
                             logic [3:0] m_in, logic [15:0] y_in);
      int        d;
      int        m;
      int        n;
      logic [15:0] y;
      date_res_t r;
      d = d_in;
      m = m_in;
      y = y_in;
      n = cnt;
      r.bad = 1'b0;
      if (m < 1 || m > 12 || d == 0 || d > days_of(y, m)) begin
        r.bad = 1'b1;
      end else begin
        case (cmd)
          CMD_DAY:        for (int i = 0; i < n; i++) prev_day(d, m, y);
          CMD_WEEK:       for (int i = 0; i < n * 7; i++) prev_day(d, m, y);
          CMD_MONTH:      for (int i = 0; i < n; i++) prev_month(d, m, y);
          CMD_YEAR:       y = y - 16'(n);
          CMD_DECADE:     y = y - 16'(n * 10);
          CMD_CENTURY:    y = y - 16'(n * 100);
          CMD_MILLENNIUM: y = y - 16'(n * 1000);
          default:        ;
        endcase
      end
      r.day = 5'(d);
      r.month = 4'(m);
      r.year = y;
      expected_q.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %0s", $time, what);
      errors++;
    endtask

    task check_result(logic [4:0] d, logic [3:0] m, logic [15:0] y, logic b);
      date_res_t e;
      if (expected_q.size() == 0) begin
        report("result item with no pending input");
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.day)
        report($sformatf("day_out got %0d exp %0d", d, e.day));
      if (m !== e.month)
        report($sformatf("month_out got %0d exp %0d", m, e.month));
      if (y !== e.year)
        report($sformatf("year_out got %0d exp %0d", $signed(y), $signed(e.year)));
      if (b !== e.bad)
        report($sformatf("bad_input got %0b exp %0b", b, e.bad));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [0:0]  out_tuser;
  logic [31:0] out_tdata;

  date_scoreboard sb = new();
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  logic [7:0] stall_phase = '0;

  gregorian_date_decrement_core #(.YEAR_WIDTH(16)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 8'd1;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (stall_phase[1:0] == 2'b00);
      default: out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[4:0], out_tdata[8:5], out_tdata[24:9], out_tuser[0]);
  end

  task send_date(logic [2:0] cmd, logic [11:0] cnt, logic [4:0] d, logic [3:0] m,
                 logic [15:0] y);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, y, m, d, cnt};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, cnt, d, m, y);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(0, 6);
    end
  endtask

  task rand_date();
    logic [2:0]  cmd;
    logic [11:0] cnt;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [15:0] y;
    int len;
    int r;
    case ($urandom_range(0, 5))
      0:       y = 16'($urandom_range(0, 16'hFFFF));
      1:       y = ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFC) + 16'($urandom_range(0, 3));
      2:       y = 16'(($urandom_range(0, 654) - 327) * 100);
      3:       y = 16'($urandom_range(0, 20) - 10);
      default: y = 16'($urandom_range(0, 6000) - 3000);
    endcase
    m = 4'($urandom_range(1, 12));
    len = sb.days_of(y, m);
    r = $urandom_range(0, 9);
    d = 5'((r < 4) ? len : (r == 4) ? 1 : $urandom_range(1, len));
    r = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: m = 4'd0;
        1: m = 4'($urandom_range(13, 15));
        2: d = 5'd0;
        default: begin
          if (len < 31) d = 5'($urandom_range(len + 1, 31));
          else m = 4'd0;
        end
      endcase
    end
    cmd = (r >= 6 && r < 9) ? CMD_UNUSED : 3'($urandom_range(0, 6));
    if (cmd == CMD_DAY || cmd == CMD_WEEK || cmd == CMD_MONTH) begin
      r = $urandom_range(0, 99);
      cnt = (r == 0) ? 12'($urandom_range(0, 4095)) :
            (r < 20) ? 12'($urandom_range(0, 400)) : 12'($urandom_range(0, 40));
    end else begin
      cnt = 12'($urandom_range(0, 4095));
    end
    send_date(cmd, cnt, d, m, y);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // year and month borrows, wraps, leap Februaries, clamps
    send_date(CMD_DAY, 12'd1, 5'd1, 4'd1, 16'd0);
    send_date(CMD_DAY, 12'd1, 5'd1, 4'd1, 16'h8000);
    send_date(CMD_DAY, 12'd1, 5'd1, 4'd3, 16'd2000);
    send_date(CMD_DAY, 12'd1, 5'd1, 4'd3, 16'd1900);
    send_date(CMD_DAY, 12'd1, 5'd1, 4'd3, 16'hFE70);
    send_date(CMD_MONTH, 12'd2, 5'd31, 4'd3, 16'd2023);
    send_date(CMD_MONTH, 12'd2, 5'd31, 4'd3, 16'd2024);
    send_date(CMD_MONTH, 12'd4095, 5'd31, 4'd12, 16'h7FFF);
    send_date(CMD_WEEK, 12'd4095, 5'd31, 4'd12, 16'd0);
    send_date(CMD_DAY, 12'd4095, 5'd1, 4'd1, 16'h8000);
    send_date(CMD_YEAR, 12'd4095, 5'd15, 4'd6, 16'h8000);
    send_date(CMD_DECADE, 12'd4095, 5'd15, 4'd6, 16'h7FFF);
    send_date(CMD_CENTURY, 12'd4095, 5'd15, 4'd6, 16'h7FFF);
    send_date(CMD_MILLENNIUM, 12'd4095, 5'd15, 4'd6, 16'h7FFF);
    send_date(CMD_YEAR, 12'd1, 5'd29, 4'd2, 16'd2024);
    send_date(CMD_DAY, 12'd0, 5'd31, 4'd12, 16'hFFFF);
    send_date(CMD_MONTH, 12'd0, 5'd31, 4'd1, 16'd1);
    send_date(CMD_UNUSED, 12'd4095, 5'd31, 4'd12, 16'd2000);
    // invalid dates
    send_date(CMD_DAY, 12'd5, 5'd10, 4'd0, 16'd2000);
    send_date(CMD_DAY, 12'd5, 5'd31, 4'd15, 16'd2000);
    send_date(CMD_WEEK, 12'd5, 5'd0, 4'd5, 16'd2000);
    send_date(CMD_MONTH, 12'd5, 5'd29, 4'd2, 16'd1900);
    send_date(CMD_YEAR, 12'd5, 5'd31, 4'd4, 16'd2000);
    send_date(CMD_DAY, 12'd5, 5'd30, 4'd2, 16'd2000);

    repeat (1500) rand_date();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
